@@ src/u8hex_pkg.sv @@
// Shared types, constants and a helper function for the UTF-8 to UCS-2 hex encoder.
package u8hex_pkg;

    // Lead and continuation byte boundaries.
    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;

    // Surrogate range of the decoded value.
    localparam logic [15:0] SURR_MIN = 16'hD800;
    localparam logic [15:0] SURR_MAX = 16'hDFFF;

    // Payload masks of lead and continuation bytes.
    localparam logic [7:0] MASK_LEAD2 = 8'h1F;
    localparam logic [7:0] MASK_LEAD3 = 8'h0F;
    localparam logic [7:0] MASK_CONT  = 8'h3F;

    // ASCII bases for hex digits.
    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_ALPHA = 7'h37;   // 'A' - 10

    // Continuation byte counts.
    localparam logic [1:0] REM_NONE = 2'd0;
    localparam logic [1:0] REM_ONE  = 2'd1;
    localparam logic [1:0] REM_TWO  = 2'd2;

    // Digit positions within one code point.
    localparam logic [1:0] DIGIT_FIRST = 2'd0;
    localparam logic [1:0] DIGIT_LAST  = 2'd3;

    // One unit of work handed from the decoder to the serializer.
    typedef struct packed {
        logic [15:0] code;    // decoded code point
        logic        digits;  // 1: four digits, 0: lone message-end result
        logic        last;    // request carried the message end flag
        logic        ok;      // message status for the final result
    } job_t;

    // Handshake between decoder and serializer.
    typedef struct packed {
        logic valid;
        job_t job;
    } job_slot_t;

    function automatic logic [6:0] nibble_to_ascii(input logic [3:0] v);
        logic [6:0] wide;
        wide = {3'b000, v};
        return (v < 4'd10) ? (ASCII_ZERO + wide) : (ASCII_ALPHA + wide);
    endfunction

endpackage

@@ src/u8hex_byte_if.sv @@
// Request channel carrying one UTF-8 byte and its message end flag.
interface u8hex_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       message_last;

    modport source (output valid, output byte_value, output message_last, input ready);
    modport sink   (input valid, input byte_value, input message_last, output ready);
endinterface

@@ src/u8hex_hex_if.sv @@
// Result channel carrying one hex digit and its message status flags.
interface u8hex_hex_if;
    logic       valid;
    logic       ready;
    logic [6:0] hex_char;
    logic       char_valid;
    logic       run_last;
    logic       message_end;
    logic       message_ok;

    modport source (output valid, output hex_char, output char_valid, output run_last,
                    output message_end, output message_ok, input ready);
    modport sink   (input valid, input hex_char, input char_valid, input run_last,
                    input message_end, input message_ok, output ready);
endinterface

@@ src/u8hex_decode.sv @@
// UTF-8 decoder: sequence state, error tracking and the one-entry job register.
module u8hex_decode
(
    input  logic                clk,
    input  logic                rst_n,
    u8hex_byte_if.sink          utf8,
    input  logic                pop,
    output u8hex_pkg::job_slot_t slot
);

    logic [15:0]       acc_reg, acc_next;
    logic [1:0]        rem_reg, rem_next;
    logic              err_reg, err_next;
    logic              any_reg, any_next;
    logic              job_valid_reg;
    u8hex_pkg::job_t   job_reg;
    u8hex_pkg::job_t   job_next;
    logic              complete;
    logic [15:0]       code;
    logic [15:0]       acc_shift;
    logic [1:0]        rem_dec;
    logic [7:0]        b;
    logic              accept;
    logic              push;

    assign b          = utf8.byte_value;
    assign utf8.ready = !job_valid_reg || pop;
    assign accept     = utf8.valid && utf8.ready;

    assign acc_shift = {acc_reg[9:0], b[5:0] & u8hex_pkg::MASK_CONT[5:0]};
    assign rem_dec   = rem_reg - 2'd1;

    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        err_next = err_reg;
        any_next = any_reg;
        complete = 1'b0;
        code     = acc_reg;
        if (!err_reg)
        begin
            if (rem_reg == u8hex_pkg::REM_NONE)
            begin
                if (!b[7])
                begin
                    code     = {8'h00, b};
                    complete = 1'b1;
                end
                else if (b >= u8hex_pkg::LEAD2_MIN && b <= u8hex_pkg::LEAD2_MAX)
                begin
                    acc_next = {8'h00, b & u8hex_pkg::MASK_LEAD2};
                    rem_next = u8hex_pkg::REM_ONE;
                end
                else if (b >= u8hex_pkg::LEAD3_MIN && b <= u8hex_pkg::LEAD3_MAX)
                begin
                    acc_next = {8'h00, b & u8hex_pkg::MASK_LEAD3};
                    rem_next = u8hex_pkg::REM_TWO;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else if (b >= u8hex_pkg::CONT_MIN && b <= u8hex_pkg::CONT_MAX)
            begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == u8hex_pkg::REM_NONE)
                begin
                    code = acc_shift;
                    if (acc_shift >= u8hex_pkg::SURR_MIN && acc_shift <= u8hex_pkg::SURR_MAX)
                        err_next = 1'b1;
                    else
                        complete = 1'b1;
                end
            end
            else
            begin
                err_next = 1'b1;
            end
        end
        // A message that ends inside a sequence is cut off.
        if (utf8.message_last && rem_next != u8hex_pkg::REM_NONE)
            err_next = 1'b1;
        if (complete)
            any_next = 1'b1;
    end

    always_comb
    begin
        job_next.code   = code;
        job_next.digits = complete;
        job_next.last   = utf8.message_last;
        job_next.ok     = !err_next && any_next;
    end

    // Only completed characters and message ends produce results.
    assign push = accept && (complete || utf8.message_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            rem_reg       <= u8hex_pkg::REM_NONE;
            err_reg       <= 1'b0;
            any_reg       <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (utf8.message_last)
                begin
                    acc_reg <= '0;
                    rem_reg <= u8hex_pkg::REM_NONE;
                    err_reg <= 1'b0;
                    any_reg <= 1'b0;
                end
                else
                begin
                    acc_reg <= acc_next;
                    rem_reg <= rem_next;
                    err_reg <= err_next;
                    any_reg <= any_next;
                end
            end
            if (push)
                job_valid_reg <= 1'b1;
            else if (pop)
                job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            job_reg <= job_next;
    end

    assign slot.valid = job_valid_reg;
    assign slot.job   = job_reg;

endmodule

@@ src/u8hex_serial.sv @@
// Serializer: walks a job out as hex digits through the output register.
module u8hex_serial
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  u8hex_pkg::job_slot_t slot,
    output logic                 pop,
    u8hex_hex_if.source          hex
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [6:0] char_reg;
    logic       cvalid_reg;
    logic       run_last_reg;
    logic       end_reg;
    logic       ok_reg;
    logic       load;
    logic       final_res;
    logic [3:0] nib;
    logic [6:0] char_next;
    logic       cvalid_next;
    logic       run_last_next;
    logic       end_next;
    logic       ok_next;

    assign load      = slot.valid && (!out_valid_reg || hex.ready);
    assign final_res = !slot.job.digits || idx_reg == u8hex_pkg::DIGIT_LAST;
    assign pop       = load && final_res;

    always_comb
    begin
        case (idx_reg)
            2'd0:    nib = slot.job.code[15:12];
            2'd1:    nib = slot.job.code[11:8];
            2'd2:    nib = slot.job.code[7:4];
            default: nib = slot.job.code[3:0];
        endcase
    end

    always_comb
    begin
        if (slot.job.digits)
        begin
            char_next   = u8hex_pkg::nibble_to_ascii(nib);
            cvalid_next = 1'b1;
        end
        else
        begin
            char_next   = '0;
            cvalid_next = 1'b0;
        end
        run_last_next = final_res;
        end_next      = final_res && slot.job.last;
        ok_next       = final_res && slot.job.last && slot.job.ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= u8hex_pkg::DIGIT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= final_res ? u8hex_pkg::DIGIT_FIRST : idx_reg + 2'd1;
            end
            else if (hex.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg     <= char_next;
            cvalid_reg   <= cvalid_next;
            run_last_reg <= run_last_next;
            end_reg      <= end_next;
            ok_reg       <= ok_next;
        end
    end

    assign hex.valid       = out_valid_reg;
    assign hex.hex_char    = char_reg;
    assign hex.char_valid  = cvalid_reg;
    assign hex.run_last    = run_last_reg;
    assign hex.message_end = end_reg;
    assign hex.message_ok  = ok_reg;

endmodule

@@ src/utf8_to_ucs2_hex_encoder_core.sv @@
// Top level of the UTF-8 to UCS-2 hex encoder: decoder feeding a digit serializer.
//
//   channel  dir  payload                                          handshake
//   utf8     in   byte_value[7:0], message_last                    valid/ready
//   hex      out  hex_char[6:0], char_valid, run_last,             valid/ready
//                 message_end, message_ok
//
// A request is decoded in the cycle it is accepted; the decoder state and a
// one-entry job register update at that edge. A request that completes a
// character yields four results, one per cycle while hex is ready, and a
// message end that completes no character yields one; other requests yield
// none. With the result side always ready, ASCII input is bound by the
// output register, which loads a single result per cycle.
// Reset is asynchronous and active low and clears all sequence state.
// A stall on hex holds the output register and the job register; the next
// request is taken in the same cycle the current job's last result loads.
module utf8_to_ucs2_hex_encoder_core
(
    input  logic         clk,
    input  logic         rst_n,
    u8hex_byte_if.sink   utf8,
    u8hex_hex_if.source  hex
);

    // Job slot between the decoder and the serializer.
    u8hex_pkg::job_slot_t slot;

    // The serializer releases the slot as the final result of a job loads.
    logic pop;

    u8hex_decode u_decode
    (
        .clk   (clk),
        .rst_n (rst_n),
        .utf8  (utf8),
        .pop   (pop),
        .slot  (slot)
    );

    u8hex_serial u_serial
    (
        .clk   (clk),
        .rst_n (rst_n),
        .slot  (slot),
        .pop   (pop),
        .hex   (hex)
    );

endmodule
